// ===== rtl/core/mips_subset_core_unit_defines.svh =====
// Assertion macros used by the back part of the core (msc_back).
`ifndef MIPS_SUBSET_CORE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_CORE_UNIT_DEFINES_SVH
// Implication checked at every edge outside reset.
`define MSC_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// Next-cycle implication checked outside reset.
`define MSC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;
   localparam int MEM_WORDS = 1024;
   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int LC_W = MEM_AW + 1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_OVF     = 2'd2;
   localparam logic [1:0] ST_MEM     = 2'd3;

   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI  = 6'h0A;
   localparam logic [5:0] OP_SLTIU = 6'h0B;
   localparam logic [5:0] OP_ANDI  = 6'h0C;
   localparam logic [5:0] OP_ORI   = 6'h0D;
   localparam logic [5:0] OP_LUI   = 6'h0F;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_LBU   = 6'h24;
   localparam logic [5:0] OP_LHU   = 6'h25;
   localparam logic [5:0] OP_SB    = 6'h28;
   localparam logic [5:0] OP_SH    = 6'h29;
   localparam logic [5:0] OP_SW    = 6'h2B;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   // One classified item passed from the front to the back part.
   typedef struct packed {
      logic        exec;
      logic [31:0] word;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);
endpackage

// ===== rtl/core/msc_front.sv =====
module msc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_func,
   input  logic [31:0]      req_word,
   output msc_pkg::cmd_type cmd_data,
   output logic             cmd_valid,
   input  logic             cmd_take
);
   import msc_pkg::*;

   // Two-entry queue between the input and the execute engine.
   cmd_type    slot_ff [2];
   cmd_type    slot_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok, pop_ok;

   assign req_full  = (count_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop_ok    = cmd_take && cmd_valid;
   assign cmd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in.exec = req_func;
      slot_in.word = req_word;
      wr_ptr_in    = wr_ptr_ff ^ push_ok;
      rd_ptr_in    = rd_ptr_ff ^ pop_ok;
      count_in     = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ===== rtl/core/msc_back.sv =====
`include "mips_subset_core_unit_defines.svh"
module msc_back (
   input  logic             clock,
   input  logic             reset,
   input  msc_pkg::cmd_type cmd_data,
   input  logic             cmd_valid,
   output logic             cmd_take,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic [1:0]       rsp_status
);
   import msc_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_DATA  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] rdata_ff;
   logic        mem_we;
   logic [MEM_AW-1:0] mem_waddr, mem_raddr;
   logic [31:0] mem_wdata;

   logic [31:0] regs_ff [32];
   logic [1:0]  state_ff, state_in;
   logic [31:0] pc_ff, pc_in;
   logic [LC_W-1:0] lc_ff, lc_in;
   logic [31:0] inst_ff, inst_in;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] o_pc_ff, o_pc_in, o_val_ff, o_val_in;
   logic        o_wr_ff, o_wr_in;
   logic [4:0]  o_idx_ff, o_idx_in;
   logic [1:0]  o_st_ff, o_st_in;
   logic        rf_we;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa;
   logic [31:0] a, b, se, imm, addr, res, next, sum, dif, pc4, lane_w;
   logic [4:0]  dest;
   logic [1:0]  st;
   logic        is_load, is_store, mem_bad, out_free;
   logic [4:0]  shamt;

   assign out_free = !out_valid_ff || rsp_pop;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_next_pc     = o_pc_ff;
   assign rsp_reg_written = o_wr_ff;
   assign rsp_reg_index   = o_idx_ff;
   assign rsp_reg_value   = o_val_ff;
   assign rsp_status      = o_st_ff;

   // Decode of the fetched instruction.
   always_comb begin
      op   = inst_ff[31:26];
      rs   = inst_ff[25:21];
      rt   = inst_ff[20:16];
      rd   = inst_ff[15:11];
      sa   = inst_ff[10:6];
      fn   = inst_ff[5:0];
      imm  = {16'h0000, inst_ff[15:0]};
      se   = {{16{inst_ff[15]}}, inst_ff[15:0]};
      a    = (rs == 5'd0) ? 32'h0 : regs_ff[rs];
      b    = (rt == 5'd0) ? 32'h0 : regs_ff[rt];
      addr = a + se;
      pc4  = pc_ff + 32'd4;
      is_load  = (op == OP_LW) || (op == OP_LHU) || (op == OP_LBU);
      is_store = (op == OP_SW) || (op == OP_SH) || (op == OP_SB);
      mem_bad  = (addr[31:2] >= 30'(MEM_WORDS));
      if ((op == OP_LW) || (op == OP_SW)) begin
         mem_bad = mem_bad || (addr[1:0] != 2'b00);
      end else if ((op == OP_LHU) || (op == OP_SH)) begin
         mem_bad = mem_bad || addr[0];
      end
   end

   // ALU and branch resolution; data-memory results use rdata_ff.
   always_comb begin
      res   = 32'h0;
      dest  = 5'd0;
      st    = ST_OK;
      next  = pc4;
      sum   = 32'h0;
      dif   = 32'h0;
      shamt = {addr[1:0], 3'b000};
      lane_w = rdata_ff;
      case (op)
         OP_RTYPE: begin
            dest = rd;
            sum  = a + b;
            dif  = a - b;
            case (fn)
               FN_ADD: begin
                  res = sum;
                  if (((a ^ sum) & (b ^ sum)) >> 31 != 32'h0) st = ST_OVF;
               end
               FN_ADDU: res = sum;
               FN_SUB: begin
                  res = dif;
                  if (((a ^ b) & (a ^ dif)) >> 31 != 32'h0) st = ST_OVF;
               end
               FN_SUBU: res = dif;
               FN_AND:  res = a & b;
               FN_OR:   res = a | b;
               FN_NOR:  res = ~(a | b);
               FN_SLT:  res = {31'h0, $signed(a) < $signed(b)};
               FN_SLTU: res = {31'h0, a < b};
               FN_SLL:  res = b << sa;
               FN_SRL:  res = b >> sa;
               FN_SRA:  res = $unsigned($signed(b) >>> sa);
               FN_JR: begin
                  next = a;
                  dest = 5'd0;
               end
               default: st = ST_ILLEGAL;
            endcase
         end
         OP_J:   next = {pc4[31:28], inst_ff[25:0], 2'b00};
         OP_JAL: begin
            next = {pc4[31:28], inst_ff[25:0], 2'b00};
            dest = 5'd31;
            res  = pc4;
         end
         OP_BEQ: if (a == b) next = pc4 + {se[29:0], 2'b00};
         OP_BNE: if (a != b) next = pc4 + {se[29:0], 2'b00};
         OP_ADDI: begin
            dest = rt;
            res  = a + se;
            if (((a ^ res) & (se ^ res)) >> 31 != 32'h0) st = ST_OVF;
         end
         OP_ADDIU: begin dest = rt; res = a + se; end
         OP_SLTI:  begin dest = rt; res = {31'h0, $signed(a) < $signed(se)}; end
         OP_SLTIU: begin dest = rt; res = {31'h0, a < se}; end
         OP_ANDI:  begin dest = rt; res = a & imm; end
         OP_ORI:   begin dest = rt; res = a | imm; end
         OP_LUI:   begin dest = rt; res = {inst_ff[15:0], 16'h0000}; end
         OP_LW, OP_LHU, OP_LBU: begin
            if (mem_bad) begin
               st = ST_MEM;
            end else begin
               dest = rt;
               lane_w = rdata_ff >> shamt;
               if (op == OP_LW) res = rdata_ff;
               else if (op == OP_LHU) res = {16'h0, lane_w[15:0]};
               else res = {24'h0, lane_w[7:0]};
            end
         end
         OP_SW, OP_SH, OP_SB: if (mem_bad) st = ST_MEM;
         default: st = ST_ILLEGAL;
      endcase
      if (st != ST_OK) next = pc_ff;
   end

   // Sequencer: a load beat writes memory from idle; an execute beat fetches,
   // latches the instruction, reads the data word for loads and stores, and commits.
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      lc_in        = lc_ff;
      inst_in      = inst_ff;
      cmd_take     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = lc_ff[MEM_AW-1:0];
      mem_wdata    = cmd_data.word;
      mem_raddr    = pc_ff[MEM_AW+1:2];
      rf_we        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      o_pc_in      = o_pc_ff;
      o_wr_in      = o_wr_ff;
      o_idx_in     = o_idx_ff;
      o_val_in     = o_val_ff;
      o_st_in      = o_st_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               if (!cmd_data.exec) begin
                  cmd_take     = 1'b1;
                  out_valid_in = 1'b1;
                  o_pc_in = pc_ff; o_wr_in = 1'b0; o_idx_in = 5'd0; o_val_in = 32'h0;
                  if (lc_ff < LC_W'(MEM_WORDS)) begin
                     mem_we = 1'b1;
                     lc_in  = lc_ff + 1'b1;
                     o_st_in = ST_OK;
                  end else begin
                     o_st_in = ST_MEM;
                  end
               end else if ((pc_ff[1:0] != 2'b00) || (pc_ff[31:2] >= 30'(MEM_WORDS))) begin
                  cmd_take     = 1'b1;
                  out_valid_in = 1'b1;
                  o_pc_in = pc_ff; o_wr_in = 1'b0; o_idx_in = 5'd0; o_val_in = 32'h0;
                  o_st_in = ST_MEM;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            inst_in  = rdata_ff;
            state_in = S_DATA;
         end
         S_DATA: begin
            // Issue the data read for a load or the read-modify for a store.
            mem_raddr = addr[MEM_AW+1:2];
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Finish: rdata_ff holds the data word when one was read.
            cmd_take     = 1'b1;
            out_valid_in = 1'b1;
            state_in     = S_IDLE;
            pc_in        = next;
            if (st == ST_OK && is_store) begin
               mem_we    = 1'b1;
               mem_waddr = addr[MEM_AW+1:2];
               if (op == OP_SW) mem_wdata = b;
               else if (op == OP_SH) mem_wdata = addr[1] ?
                  {b[15:0], rdata_ff[15:0]} : {rdata_ff[31:16], b[15:0]};
               else begin
                  mem_wdata = rdata_ff;
                  case (addr[1:0])
                     2'd0: mem_wdata[7:0]   = b[7:0];
                     2'd1: mem_wdata[15:8]  = b[7:0];
                     2'd2: mem_wdata[23:16] = b[7:0];
                     default: mem_wdata[31:24] = b[7:0];
                  endcase
               end
            end
            rf_we    = (st == ST_OK) && (dest != 5'd0);
            o_pc_in  = next;
            o_st_in  = st;
            o_wr_in  = rf_we;
            o_idx_in = rf_we ? dest : 5'd0;
            o_val_in = rf_we ? res : 32'h0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= 32'h0;
      end else if (rf_we) begin
         regs_ff[dest] <= res;
      end
   end

   always_ff @(posedge clock) begin
      inst_ff  <= inst_in;
      o_pc_ff  <= o_pc_in;
      o_wr_ff  <= o_wr_in;
      o_idx_ff <= o_idx_in;
      o_val_ff <= o_val_in;
      o_st_ff  <= o_st_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= 32'h0;
         lc_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         lc_ff        <= lc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `MSC_ASSERT_IMPL(a_wr_nonzero, clock, reset, !rsp_empty && rsp_reg_written,
                    rsp_reg_index != 5'd0, "write to register zero reported")
   `MSC_ASSERT_IMPL(a_fault_nowr, clock, reset, !rsp_empty && (rsp_status != ST_OK),
                    !rsp_reg_written, "faulting beat reports a write")
   `MSC_ASSERT_NEXT(a_exec_seq, clock, reset, state_ff == S_EXEC, state_ff == S_DATA,
                    "execute sequence broken")
endmodule

// ===== rtl/core/mips_subset_core_unit.sv =====
// Small MIPS32 integer subset interpreter with one unified word memory.
// Input channel (req_): push a beat while full is low. req_func = 0 loads
// req_word at the next program word address; req_func = 1 executes the
// instruction at the current program counter. req_word is ignored then.
// Result channel (rsp_): one beat per input beat, in order. A beat waits
// while rsp_empty is low and is taken when rsp_pop is high.
// A two-entry queue separates the input side from the execute engine, so
// the sender may push while the engine is busy or the receiver stalls.
// A load beat's result is registered from idle; an execute beat passes
// fetch, instruction register, data read and commit. The engine takes
// one load per cycle while the receiver takes results, but an execute
// beat keeps it busy until commit, as the single memory port is used for
// fetch and data access.
// When the receiver stalls, the engine holds its finished result and stops
// taking new work; the queue then fills and full rises.
// Reset clears all registers, the program counter, the load count and both
// channels. Memory contents are undefined until loaded.
module mips_subset_core_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [31:0] req_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic [1:0]  rsp_status
);
   import msc_pkg::*;

   // Command beats travel from the front queue to the engine.
   cmd_type cmd_data;
   logic    cmd_valid, cmd_take;

   msc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_func (req_func),
      .req_word (req_word),
      .cmd_data (cmd_data),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take)
   );

   msc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_data       (cmd_data),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_reg_written(rsp_reg_written),
      .rsp_reg_index  (rsp_reg_index),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_status     (rsp_status)
   );
endmodule

// ===== verif/mips_subset_core_unit_tb.sv =====
module mips_subset_core_unit_tb;
   import msc_pkg::*;

   // Item codes on req_func.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EXEC = 1'b1;

   // Bytes 0..255 hold data that the preamble loads; every load and store
   // of the normal run stays inside this window.
   localparam int DATA_WORDS = 64;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_func = 1'b0;
   logic [31:0] req_word = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_reg_written;
   logic [4:0]  rsp_reg_index;
   logic [31:0] rsp_reg_value;
   logic [1:0]  rsp_status;

   // One predicted result beat.
   typedef struct {
      logic [31:0] next_pc;
      logic        written;
      logic [4:0]  index;
      logic [31:0] value;
      logic [1:0]  status;
   } outcome_type;

   outcome_type outcome_q[$];

   // Shadow copy of the architectural state.
   logic [31:0] gpr [32];
   logic [31:0] pc_q;
   int          loaded;
   logic [31:0] mem_q [MEM_WORDS];

   int gap_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int cycles = 0;
   // The receiver starts a long hold-off whenever this ticket moves.
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;

   mips_subset_core_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_func(req_func),
      .req_word(req_word),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_next_pc(rsp_next_pc),
      .rsp_reg_written(rsp_reg_written),
      .rsp_reg_index(rsp_reg_index),
      .rsp_reg_value(rsp_reg_value),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // The run is bounded so that a hung handshake cannot stall the job.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Instruction encoders.
   function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sa, logic [5:0] fn);
      return {OP_RTYPE, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   function automatic bit add_ovf(logic [31:0] a, logic [31:0] b, logic [31:0] s);
      return (a[31] == b[31]) && (s[31] != a[31]);
   endfunction

   function automatic bit access_ok(logic [31:0] addr, int size);
      if ((addr & (size - 1)) != 0)
         return 0;
      return addr[31:2] < MEM_WORDS;
   endfunction

   // Predicts the result of one accepted beat and advances the shadow state.
   function automatic outcome_type core_step(logic f, logic [31:0] w);
      outcome_type o;
      logic [31:0] ins, a, b, se, addr, res, nxt, word;
      logic [4:0]  rs, rt, rd, sa, dest;
      logic [5:0]  op, fn;
      logic [1:0]  st;
      int          lane;
      o.next_pc = pc_q;
      o.written = 1'b0;
      o.index = '0;
      o.value = '0;
      o.status = ST_OK;
      if (f == CMD_LOAD) begin
         if (loaded < MEM_WORDS) begin
            mem_q[loaded] = w;
            loaded++;
         end else begin
            o.status = ST_MEM;
         end
         return o;
      end
      if (pc_q[1:0] != 2'b00 || pc_q[31:2] >= MEM_WORDS) begin
         o.status = ST_MEM;
         return o;
      end
      ins = mem_q[pc_q[31:2]];
      op = ins[31:26];
      rs = ins[25:21];
      rt = ins[20:16];
      rd = ins[15:11];
      sa = ins[10:6];
      fn = ins[5:0];
      a = gpr[rs];
      b = gpr[rt];
      se = {{16{ins[15]}}, ins[15:0]};
      addr = a + se;
      st = ST_OK;
      dest = '0;
      res = '0;
      nxt = pc_q + 32'd4;
      case (op)
         OP_RTYPE: begin
            dest = rd;
            case (fn)
               FN_ADD: begin
                  res = a + b;
                  if (add_ovf(a, b, res)) st = ST_OVF;
               end
               FN_ADDU: res = a + b;
               FN_SUB: begin
                  res = a - b;
                  if (a[31] != b[31] && res[31] != a[31]) st = ST_OVF;
               end
               FN_SUBU: res = a - b;
               FN_AND:  res = a & b;
               FN_OR:   res = a | b;
               FN_NOR:  res = ~(a | b);
               FN_SLT:  res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               FN_SLTU: res = (a < b) ? 32'd1 : 32'd0;
               FN_SLL:  res = b << sa;
               FN_SRL:  res = b >> sa;
               FN_SRA:  res = $signed(b) >>> sa;
               FN_JR: begin
                  nxt = a;
                  dest = '0;
               end
               default: st = ST_ILLEGAL;
            endcase
         end
         OP_J: nxt = {nxt[31:28], ins[25:0], 2'b00};
         OP_JAL: begin
            res = nxt;
            dest = 5'd31;
            nxt = {nxt[31:28], ins[25:0], 2'b00};
         end
         OP_BEQ: if (a == b) nxt = nxt + (se << 2);
         OP_BNE: if (a != b) nxt = nxt + (se << 2);
         OP_ADDI: begin
            dest = rt;
            res = a + se;
            if (add_ovf(a, se, res)) st = ST_OVF;
         end
         OP_ADDIU: begin dest = rt; res = a + se; end
         OP_SLTI:  begin dest = rt; res = ($signed(a) < $signed(se)) ? 32'd1 : 32'd0; end
         OP_SLTIU: begin dest = rt; res = (a < se) ? 32'd1 : 32'd0; end
         OP_ANDI:  begin dest = rt; res = a & {16'h0, ins[15:0]}; end
         OP_ORI:   begin dest = rt; res = a | {16'h0, ins[15:0]}; end
         OP_LUI:   begin dest = rt; res = {ins[15:0], 16'h0}; end
         OP_LW: begin
            if (!access_ok(addr, 4)) st = ST_MEM;
            else begin dest = rt; res = mem_q[addr[31:2]]; end
         end
         OP_LHU: begin
            if (!access_ok(addr, 2)) st = ST_MEM;
            else begin
               dest = rt;
               res = (mem_q[addr[31:2]] >> (addr[1] * 16)) & 32'h0000FFFF;
            end
         end
         OP_LBU: begin
            if (!access_ok(addr, 1)) st = ST_MEM;
            else begin
               dest = rt;
               res = (mem_q[addr[31:2]] >> (addr[1:0] * 8)) & 32'h000000FF;
            end
         end
         OP_SW: begin
            if (!access_ok(addr, 4)) st = ST_MEM;
            else mem_q[addr[31:2]] = b;
         end
         OP_SH: begin
            if (!access_ok(addr, 2)) st = ST_MEM;
            else begin
               lane = addr[1] * 16;
               word = mem_q[addr[31:2]] & ~(32'h0000FFFF << lane);
               mem_q[addr[31:2]] = word | ((b & 32'h0000FFFF) << lane);
            end
         end
         OP_SB: begin
            if (!access_ok(addr, 1)) st = ST_MEM;
            else begin
               lane = addr[1:0] * 8;
               word = mem_q[addr[31:2]] & ~(32'h000000FF << lane);
               mem_q[addr[31:2]] = word | ((b & 32'h000000FF) << lane);
            end
         end
         default: st = ST_ILLEGAL;
      endcase
      // A fault leaves the PC on the faulting instruction and writes nothing.
      if (st != ST_OK) begin
         nxt = pc_q;
      end else if (dest != 5'd0) begin
         gpr[dest] = res;
         o.written = 1'b1;
         o.index = dest;
         o.value = res;
      end
      pc_q = nxt;
      o.next_pc = nxt;
      o.status = st;
      return o;
   endfunction

   // Offers one beat, idling first at the current sender rate, and records
   // the prediction at the edge that accepts it.
   task automatic send_item(logic f, logic [31:0] w);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_func <= f;
      req_word <= w;
      do @(posedge clock); while (req_full);
      outcome_q.push_back(core_step(f, w));
   endtask

   // Drops the input and pauses until every predicted beat has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
   endtask

   // Loads w at the PC and executes it. Slots that a forward jump skipped
   // are filled with random words that are never fetched.
   task automatic exec_word(logic [31:0] w);
      while (pc_q[31:2] > loaded)
         send_item(CMD_LOAD, $urandom);
      send_item(CMD_LOAD, w);
      send_item(CMD_EXEC, $urandom);
   endtask

   // Builds a target in r27 and jumps through it with jr.
   task automatic jr_to(logic [31:0] target);
      exec_word(enc_i(OP_LUI, 5'($urandom), 5'd27, target[31:16]));
      exec_word(enc_i(OP_ORI, 5'd27, 5'd27, target[15:0]));
      exec_word(enc_r(5'd27, 5'($urandom), 5'($urandom), 5'($urandom), FN_JR));
   endtask

   function automatic logic [5:0] alu_fn(int i);
      case (i)
         0: return FN_ADD;
         1: return FN_ADDU;
         2: return FN_SUB;
         3: return FN_SUBU;
         4: return FN_AND;
         5: return FN_OR;
         6: return FN_NOR;
         7: return FN_SLT;
         8: return FN_SLTU;
         9: return FN_SLL;
         10: return FN_SRL;
         default: return FN_SRA;
      endcase
   endfunction

   function automatic logic [5:0] imm_op(int i);
      case (i)
         0: return OP_ADDI;
         1: return OP_ADDIU;
         2: return OP_SLTI;
         3: return OP_SLTIU;
         4: return OP_ANDI;
         5: return OP_ORI;
         default: return OP_LUI;
      endcase
   endfunction

   function automatic logic [5:0] mem_op(int i);
      case (i)
         0: return OP_LW;
         1: return OP_LHU;
         2: return OP_LBU;
         3: return OP_SW;
         4: return OP_SH;
         default: return OP_SB;
      endcase
   endfunction

   // A random instruction that is legal in the present state: it is loaded
   // at the PC and runs at once, so overflow can be steered around here.
   function automatic logic [31:0] random_inst();
      int          kind, size;
      logic [4:0]  rs, rt;
      logic [5:0]  op, fn;
      logic [15:0] imm;
      logic [31:0] se;
      kind = $urandom_range(99);
      rs = 5'($urandom);
      rt = ($urandom_range(3) == 0) ? rs : 5'($urandom);
      imm = 16'($urandom);
      se = {{16{imm[15]}}, imm};
      if (kind < 35) begin
         fn = alu_fn($urandom_range(11));
         if (fn == FN_ADD && add_ovf(gpr[rs], gpr[rt], gpr[rs] + gpr[rt]))
            fn = FN_ADDU;
         if (fn == FN_SUB && gpr[rs][31] != gpr[rt][31]
             && (gpr[rs] - gpr[rt]) >> 31 != gpr[rs][31])
            fn = FN_SUBU;
         return enc_r(rs, rt, 5'($urandom), 5'($urandom), fn);
      end
      if (kind < 60) begin
         op = imm_op($urandom_range(6));
         if (op == OP_ADDI && add_ovf(gpr[rs], se, gpr[rs] + se))
            op = OP_ADDIU;
         return enc_i(op, rs, rt, imm);
      end
      if (kind < 80) begin
         op = mem_op($urandom_range(5));
         size = (op == OP_LW || op == OP_SW) ? 4 : (op == OP_LHU || op == OP_SH) ? 2 : 1;
         imm = 16'($urandom_range(4 * DATA_WORDS - 1) & ~(size - 1));
         return enc_i(op, 5'd0, rt, imm);
      end
      // Control flow only ever moves forward, so no word runs twice.
      if (kind < 92)
         return enc_i(($urandom_range(1) != 0) ? OP_BEQ : OP_BNE, rs, rt,
                      16'($urandom_range(3)));
      return enc_j(($urandom_range(1) != 0) ? OP_J : OP_JAL,
                   26'(pc_q[31:2] + 1 + $urandom_range(3)));
   endfunction

   task automatic run_until(int words, int gap, int stall);
      gap_pct = gap;
      stall_pct = stall;
      while (loaded < words) begin
         if ($urandom_range(29) == 0)
            jr_to(32'((pc_q[31:2] + 3 + $urandom_range(3)) * 4));
         else
            exec_word(random_inst());
      end
   endtask

   // Word 0 jumps over the data window; words 1 and 2 hold all ones and zero, the rest random data.
   task automatic test_preamble();
      gap_pct = 0;
      stall_pct = 0;
      send_item(CMD_LOAD, enc_j(OP_J, 26'(DATA_WORDS)));
      send_item(CMD_LOAD, 32'hFFFFFFFF);
      send_item(CMD_LOAD, 32'h00000000);
      while (loaded < DATA_WORDS)
         send_item(CMD_LOAD, $urandom);
      send_item(CMD_EXEC, $urandom);
   endtask

   // Every operation but j, with extreme operands, register zero as the
   // destination, both byte and halfword lanes, and taken and untaken branches.
   task automatic test_directed_ops();
      exec_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF));
      exec_word(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
      exec_word(enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000));
      exec_word(enc_i(OP_ADDIU, 5'd0, 5'd3, 16'h7FFF));
      exec_word(enc_i(OP_ADDI, 5'd0, 5'd4, 16'h8000));
      exec_word(enc_r(5'd1, 5'd1, 5'd0, 5'd0, FN_ADD));
      exec_word(enc_r(5'd1, 5'd2, 5'd5, 5'd0, FN_ADDU));
      exec_word(enc_r(5'd3, 5'd1, 5'd6, 5'd0, FN_SUB));
      exec_word(enc_r(5'd2, 5'd3, 5'd6, 5'd0, FN_SUBU));
      exec_word(enc_r(5'd1, 5'd4, 5'd7, 5'd0, FN_AND));
      exec_word(enc_r(5'd2, 5'd3, 5'd7, 5'd0, FN_OR));
      exec_word(enc_r(5'd0, 5'd0, 5'd8, 5'd0, FN_NOR));
      exec_word(enc_r(5'd2, 5'd3, 5'd9, 5'd0, FN_SLT));
      exec_word(enc_r(5'd2, 5'd3, 5'd9, 5'd0, FN_SLTU));
      exec_word(enc_r(5'd0, 5'd1, 5'd10, 5'd31, FN_SLL));
      exec_word(enc_r(5'd0, 5'd1, 5'd10, 5'd31, FN_SRL));
      exec_word(enc_r(5'd0, 5'd2, 5'd11, 5'd31, FN_SRA));
      exec_word(enc_i(OP_SLTI, 5'd1, 5'd12, 16'h0000));
      exec_word(enc_i(OP_SLTIU, 5'd3, 5'd12, 16'hFFFF));
      exec_word(enc_i(OP_ANDI, 5'd1, 5'd13, 16'hFFFF));
      exec_word(enc_i(OP_SW, 5'd0, 5'd1, 16'd252));
      exec_word(enc_i(OP_SH, 5'd0, 5'd3, 16'd254));
      exec_word(enc_i(OP_SB, 5'd0, 5'd0, 16'd253));
      exec_word(enc_i(OP_LW, 5'd0, 5'd14, 16'd252));
      exec_word(enc_i(OP_LHU, 5'd0, 5'd15, 16'd254));
      exec_word(enc_i(OP_LBU, 5'd0, 5'd16, 16'd255));
      exec_word(enc_i(OP_BEQ, 5'd0, 5'd0, 16'd2));
      exec_word(enc_i(OP_BNE, 5'd1, 5'd0, 16'd0));
      exec_word(enc_i(OP_BEQ, 5'd1, 5'd0, 16'd3));
      exec_word(enc_j(OP_JAL, 26'(pc_q[31:2] + 2)));
      jr_to(32'((pc_q[31:2] + 3) * 4));
   endtask

   // A long receiver hold-off while the sender streams without gaps, so the
   // block fills and raises full; then the sender waits for every result.
   task automatic test_backpressure();
      gap_pct = 0;
      stall_pct = 0;
      hold_ticket++;
      repeat (20)
         exec_word(random_inst());
      wait_drained();
   endtask

   // A fault leaves the PC in place, so it ends execution for the run; one
   // kind is picked per run and then executed again to show it stays put.
   task automatic test_fault();
      logic [5:0] code;
      gap_pct = 0;
      stall_pct = 0;
      case ($urandom_range(11))
         0: begin
            do code = 6'($urandom);
            while (code inside {OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU,
                                OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_LBU,
                                OP_LHU, OP_SB, OP_SH, OP_SW});
            exec_word({code, 26'($urandom)});
         end
         1: begin
            do code = 6'($urandom);
            while (code inside {FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_ADD, FN_ADDU, FN_SUB,
                                FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU});
            exec_word(enc_r(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), code));
         end
         2: begin
            exec_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'h7FFF));
            exec_word(enc_r(5'd1, 5'd1, 5'd2, 5'd0, FN_ADD));
         end
         3: begin
            exec_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'h7FFF));
            exec_word(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
            exec_word(enc_i(OP_ADDI, 5'd1, 5'd2, 16'h0001));
         end
         4: begin
            exec_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));
            exec_word(enc_i(OP_ADDIU, 5'd0, 5'd3, 16'h0001));
            exec_word(enc_r(5'd1, 5'd3, 5'd2, 5'd0, FN_SUB));
         end
         5: exec_word(enc_i(OP_LW, 5'd0, 5'd2, 16'd2));
         6: exec_word(enc_i(OP_SH, 5'd0, 5'd2, 16'd1));
         7: exec_word(enc_i(OP_LHU, 5'd0, 5'd2, 16'd3));
         8: exec_word(enc_i(OP_SW, 5'd0, 5'd2, 16'h1000));
         9: exec_word(enc_i(OP_LBU, 5'd0, 5'd2, 16'hFFFC));
         10: jr_to(32'((pc_q[31:2] + 3) * 4 + 2));
         default: jr_to(32'h00001000);
      endcase
      repeat (3)
         send_item(CMD_EXEC, $urandom);
   endtask

   // Fills the rest of memory, then offers loads to a full memory and one execute.
   task automatic test_memory_full();
      gap_pct = 36;
      stall_pct = 36;
      while (loaded < MEM_WORDS)
         send_item(CMD_LOAD, $urandom);
      repeat (6)
         send_item(CMD_LOAD, $urandom);
      send_item(CMD_EXEC, $urandom);
   endtask

   // Receiver: random stalls at the current rate, or a long hold-off when
   // a test asks for one.
   always @(negedge clock) begin
      if (hold_seen != hold_ticket) begin
         hold_seen <= hold_ticket;
         hold_left <= 150;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Each accepted result beat is compared with the oldest prediction.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result beat, next_pc %h", $time, rsp_next_pc);
            errors++;
         end else begin
            e = outcome_q.pop_front();
            check_field("next_pc", e.next_pc, rsp_next_pc);
            check_field("reg_written", 32'(e.written), 32'(rsp_reg_written));
            check_field("reg_index", 32'(e.index), 32'(rsp_reg_index));
            check_field("reg_value", e.value, rsp_reg_value);
            check_field("status", 32'(e.status), 32'(rsp_status));
         end
      end
   end

   initial begin
      for (int i = 0; i < 32; i++)
         gpr[i] = '0;
      pc_q = '0;
      loaded = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_preamble();
      test_directed_ops();
      wait_drained();
      run_until(130, 0, 0);
      run_until(170, 57, 0);
      test_backpressure();
      run_until(210, 0, 57);
      run_until(250, 36, 36);
      wait_drained();
      run_until(270, 0, 0);
      test_fault();
      test_memory_full();

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && outcome_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/msc_pkg.sv
rtl/core/msc_front.sv
rtl/core/msc_back.sv
rtl/core/mips_subset_core_unit.sv
verif/mips_subset_core_unit_tb.sv
